FILE: design/lsce_pkg.sv
// Shared types and constants for the line sensor centroid error unit.
package lsce_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int IDX_W        = $clog2(SENSOR_COUNT);
    localparam int WEIGHT_W     = 16;
    localparam int SUM_W        = 20;   // even, so the divider retires two bits a cycle
    localparam int CNT_W        = 4;
    localparam int CFG_IDX_W    = 4;
    localparam int OUT_DATA_W   = 48;   // 44 payload bits padded to whole bytes

    // Build-time pin polarity: 1 means a low pin level marks an active sensor
    localparam logic ACTIVE_LOW = 1'b1;

    localparam logic [CNT_W-1:0] CROSS_THRESHOLD = 4'd6;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_LOST  = 2'd1,
        STATUS_CROSS = 2'd2
    } track_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV,
        ST_DONE
    } state_t;

    // Result of the serial weighted sum
    typedef struct packed {
        logic [SUM_W-1:0] sum;    // two's complement
        logic [CNT_W-1:0] count;
    } acc_result_t;

endpackage

FILE: design/lsce_accum.sv
// Serial accumulator: walks the active mask one sensor per cycle, summing weights.
module lsce_accum (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   start,
    input  logic [lsce_pkg::SENSOR_COUNT-1:0]                      mask,
    input  logic [lsce_pkg::SENSOR_COUNT-1:0][lsce_pkg::WEIGHT_W-1:0] weights,
    output logic                                                   done,
    output lsce_pkg::acc_result_t                                  result
);
    import lsce_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [SENSOR_COUNT-1:0] mask_reg, mask_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [WEIGHT_W-1:0]     cur_weight;

    assign cur_weight = weights[idx_reg];

    // One sensor per cycle: the mask shifts out LSB first
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        mask_next = mask_reg;
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = '0;
            mask_next = mask;
            sum_next  = '0;
            cnt_next  = '0;
        end else if (busy_reg) begin
            if (mask_reg[0]) begin
                sum_next = sum_reg + {{(SUM_W-WEIGHT_W){cur_weight[WEIGHT_W-1]}}, cur_weight};
                cnt_next = cnt_reg + 1'b1;
            end
            mask_next = mask_reg >> 1;
            idx_next  = idx_reg + 1'b1;
            if (idx_reg == IDX_W'(SENSOR_COUNT-1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        mask_reg <= mask_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
    end

    assign done         = done_reg;
    assign result.sum   = sum_reg;
    assign result.count = cnt_reg;

endmodule

FILE: design/lsce_div.sv
// Radix-4 restoring divider: signed sum by sensor count, two quotient bits per cycle.
module lsce_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  lsce_pkg::acc_result_t         operands,
    output logic                          done,
    output logic [lsce_pkg::WEIGHT_W-1:0] quotient
);
    import lsce_pkg::*;

    localparam int DIV_STEPS = SUM_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [SUM_W-1:0]  magnitude;
    logic [SUM_W-1:0]  signed_quo;
    logic [CNT_W:0]    trial_a, trial_b;
    logic [CNT_W-1:0]  rem_mid, rem_fin;
    logic              bit_a, bit_b;

    // Magnitude of the dividend; the sign is applied after division
    assign magnitude = operands.sum[SUM_W-1] ? (~operands.sum + 1'b1) : operands.sum;

    // Two dependent restoring steps on narrow remainders
    always_comb begin
        trial_a = {rem_reg, quo_reg[SUM_W-1]};
        bit_a   = (trial_a >= {1'b0, dvs_reg});
        rem_mid = bit_a ? CNT_W'(trial_a - {1'b0, dvs_reg}) : trial_a[CNT_W-1:0];
        trial_b = {rem_mid, quo_reg[SUM_W-2]};
        bit_b   = (trial_b >= {1'b0, dvs_reg});
        rem_fin = bit_b ? CNT_W'(trial_b - {1'b0, dvs_reg}) : trial_b[CNT_W-1:0];
    end

    // Sequencing of the iterations
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = magnitude;
            rem_next  = '0;
            dvs_next  = operands.count;
            neg_next  = operands.sum[SUM_W-1];
        end else if (busy_reg) begin
            quo_next  = {quo_reg[SUM_W-3:0], bit_a, bit_b};
            rem_next  = rem_fin;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS-1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    // Truncation toward zero: negate the magnitude quotient for a negative sum
    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[WEIGHT_W-1:0];
    assign done       = done_reg;

endmodule

FILE: design/line_sensor_centroid_error_unit.sv
// Top level of the line sensor centroid error unit: control, weights, output register.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata: pin_levels
//  m_       out  m_tvalid/m_tready  m_tdata: mask/total/errors, m_tuser: track status
//  cfg_     in   cfg_valid/ready    cfg_index, cfg_data: sensor weight writes
//
// A snapshot passes through the serial accumulator and, when a line is seen, the
// radix-4 divider; when none is seen, the divider is skipped.
// Reset (aresetn low, synchronous) zeroes the weights and the saved error.
// The result waits in the output register; a new snapshot is accepted meanwhile,
// and the block holds in its final state only if the previous result is still pending.
module line_sensor_centroid_error_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] pin_levels
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] active_mask, [11:8] active_total, [27:12] steer_error,
    // [43:28] recent_valid_error, [47:44] zero
    output logic [lsce_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [1:0]                        m_tuser,   // [1:0] track_status
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lsce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsce_pkg::WEIGHT_W-1:0]     cfg_data
);
    import lsce_pkg::*;

    state_t                                   state_reg, state_next;
    logic [SENSOR_COUNT-1:0][WEIGHT_W-1:0]    weight_reg;
    logic [WEIGHT_W-1:0]                      saved_error_reg, saved_error_next;
    logic [SENSOR_COUNT-1:0]                  mask_reg;
    logic [SENSOR_COUNT-1:0]                  in_mask;
    logic                                     m_tvalid_reg;
    logic [SENSOR_COUNT-1:0]                  out_mask_reg;
    logic [CNT_W-1:0]                         out_total_reg;
    logic [WEIGHT_W-1:0]                      out_err_reg;
    logic [WEIGHT_W-1:0]                      out_recent_reg;
    track_status_t                            out_status_reg;
    logic                                     in_fire;
    logic                                     acc_start, acc_done;
    logic                                     div_start, div_done;
    logic                                     out_load;
    acc_result_t                              acc_res;
    logic [WEIGHT_W-1:0]                      div_quo;
    logic                                     line_lost;
    logic [WEIGHT_W-1:0]                      err_value;
    track_status_t                            status_value;

    // Polarity conversion of the raw pins
    assign in_mask = ACTIVE_LOW ? ~s_tdata : s_tdata;
    assign in_fire = s_tvalid && s_tready;

    lsce_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (acc_start),
        .mask    (in_mask),
        .weights (weight_reg),
        .done    (acc_done),
        .result  (acc_res)
    );

    lsce_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .operands (acc_res),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (acc_done) state_next = (acc_res.count == '0) ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (div_done) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_ACCUM: div_start = acc_done && (acc_res.count != '0);
            ST_DIV:   ;
            ST_DONE:  out_load  = !m_tvalid_reg || m_tready;
            default:  ;
        endcase
    end

    assign acc_start = in_fire;

    // Result selection and saved error update
    always_comb begin
        line_lost        = (acc_res.count == '0);
        err_value        = line_lost ? saved_error_reg : div_quo;
        saved_error_next = err_value;
        if (line_lost)
            status_value = STATUS_LOST;
        else if (acc_res.count >= CROSS_THRESHOLD)
            status_value = STATUS_CROSS;
        else
            status_value = STATUS_OK;
    end

    // Control state, weights and saved error
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            weight_reg      <= '0;
            saved_error_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready && !cfg_index[CFG_IDX_W-1])
                weight_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
            if (out_load) begin
                saved_error_reg <= saved_error_next;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg    <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) mask_reg <= in_mask;
        if (out_load) begin
            out_mask_reg   <= mask_reg;
            out_total_reg  <= acc_res.count;
            out_err_reg    <= err_value;
            out_recent_reg <= saved_error_next;
            out_status_reg <= status_value;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(OUT_DATA_W-SENSOR_COUNT-CNT_W-2*WEIGHT_W){1'b0}},
                        out_recent_reg, out_err_reg, out_total_reg, out_mask_reg};
    assign m_tuser   = out_status_reg;

    // Checks
    a_err_matches_saved: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_err_reg == out_recent_reg))
        else $error("steering error differs from saved error");

    a_lost_iff_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_status_reg == STATUS_LOST) == (out_total_reg == '0)))
        else $error("lost status does not match empty count");

    a_cross_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_total_reg >= CROSS_THRESHOLD)) |-> (out_status_reg == STATUS_CROSS))
        else $error("crossing not flagged");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (acc_res.count != '0))
        else $error("divider started with zero count");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_ACCUM))
        else $error("accepted snapshot did not start accumulation");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the line sensor centroid error unit.
module tb;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 5;
    localparam int ITEMS_PER_PHASE  = 100;
    localparam int SETTLE_CYCLES    = 40;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [7:0]                        s_tdata;    // [7:0] pin_levels
    logic                              m_tvalid;
    logic                              m_tready;
    // [7:0] active_mask, [11:8] active_total, [27:12] steer_error,
    // [43:28] recent_valid_error, [47:44] zero
    logic [lsce_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic [1:0]                        m_tuser;    // [1:0] track_status
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [lsce_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [lsce_pkg::WEIGHT_W-1:0]     cfg_data;

    // One predicted result transaction
    typedef struct {
        logic [7:0]                 mask;
        logic [3:0]                 total;
        logic [15:0]                error;
        logic [15:0]                recent;
        lsce_pkg::track_status_t    status;
    } centroid_result_t;

    // Keeps its own copy of the weights and the saved error, predicts each
    // snapshot and checks results in order.
    class centroid_tracker;
        logic signed [15:0] weight [lsce_pkg::SENSOR_COUNT];
        logic signed [15:0] saved_error;
        centroid_result_t   pending_results [$];
        int                 errors;

        function new();
            foreach (weight[k]) weight[k] = '0;
            saved_error = '0;
            errors = 0;
        endfunction

        // Indexes past the last sensor are ignored by the block
        function void write_weight(logic [3:0] idx, logic [15:0] value);
            if (idx < lsce_pkg::SENSOR_COUNT) weight[idx[2:0]] = value;
        endfunction

        function void predict_snapshot(logic [7:0] pins);
            centroid_result_t r;
            int               weight_sum;
            int               quotient;
            int unsigned      hits;
            r.mask = lsce_pkg::ACTIVE_LOW ? ~pins : pins;
            weight_sum = 0;
            hits = 0;
            for (int k = 0; k < lsce_pkg::SENSOR_COUNT; k++) begin
                if (r.mask[k]) begin
                    hits++;
                    weight_sum += int'(weight[k]);
                end
            end
            r.total = 4'(hits);
            if (hits == 0) begin
                // line lost: repeat the saved error, keep it unchanged
                r.error  = saved_error;
                r.status = lsce_pkg::STATUS_LOST;
            end else begin
                // int division truncates toward zero
                quotient = weight_sum / int'(hits);
                saved_error = 16'(quotient);
                r.error  = 16'(quotient);
                r.status = (hits >= lsce_pkg::CROSS_THRESHOLD) ?
                           lsce_pkg::STATUS_CROSS : lsce_pkg::STATUS_OK;
            end
            r.recent = saved_error;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [lsce_pkg::OUT_DATA_W-1:0] data,
                                   logic [1:0] status_bits);
            centroid_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%h",
                         $time, data, status_bits);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("active_mask", 16'(want.mask), 16'(data[7:0]));
            compare_field("active_total", 16'(want.total), 16'(data[11:8]));
            compare_field("steer_error", want.error, data[27:12]);
            compare_field("recent_valid_error", want.recent, data[43:28]);
            compare_field("tdata padding", 16'd0, 16'(data[47:44]));
            compare_field("track_status", 16'(want.status), 16'(status_bits));
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    centroid_tracker tracker = new();

    logic [15:0] weight_plan [lsce_pkg::SENSOR_COUNT];
    bit          src_idling;
    bit          sink_idling;
    bit          sink_hold_request;
    int          stall_cycles;

    line_sensor_centroid_error_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Active-sensor pattern to raw pin levels
    function automatic logic [7:0] sensor_pins(logic [7:0] seen);
        return lsce_pkg::ACTIVE_LOW ? ~seen : seen;
    endfunction

    // Mostly line-like patterns: one or two adjacent sensors, crossings, lost line
    function automatic logic [7:0] pick_levels();
        logic [7:0]  seen;
        int unsigned pos;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: seen = 8'($urandom);
            4, 5:       seen = 8'd1 << $urandom_range(0, 7);
            6: begin
                pos  = $urandom_range(0, 6);
                seen = 8'd3 << pos;
            end
            7:          seen = 8'h00;
            default: begin
                seen = 8'hFF;
                seen[$urandom_range(0, 7)] = 1'b0;
                if ($urandom_range(0, 1) == 1) seen[$urandom_range(0, 7)] = 1'b0;
            end
        endcase
        return sensor_pins(seen);
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // Leaves cfg_valid high; the caller lowers it after the batch
    task automatic write_cfg(input logic [3:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_weight(idx, value);
    endtask

    // Write all weights from weight_plan, then some writes to unused indexes
    task automatic load_weights(input int unsigned stray_writes);
        int unsigned k;
        for (k = 0; k < lsce_pkg::SENSOR_COUNT; k++) write_cfg(4'(k), weight_plan[k]);
        repeat (stray_writes) write_cfg(4'($urandom_range(8, 15)), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_snapshot(input logic [7:0] levels);
        int unsigned gap;
        if (src_idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= levels;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.predict_snapshot(levels);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.outstanding() != 0) @(posedge aclk);
    endtask

    // Result receiver: random stall bursts, ready stretches, one long hold
    initial begin : result_sink
        int unsigned span;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_request) begin
                sink_hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
            end else if (sink_idling && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                span = $urandom_range(1, 7);
                repeat (span) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                span = $urandom_range(1, 12);
                repeat (span) @(posedge aclk);
            end
        end
    end

    // Result check and watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no transaction for %0d cycles",
                         $time, WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [7:0] ramp_masks [15];
        int         phase;
        int         n;
        bit         last_phase;

        ramp_masks = '{8'h01, 8'h80, 8'h00, 8'h18, 8'h07, 8'hE0, 8'h3F, 8'h1F,
                       8'hFF, 8'hFE, 8'h7F, 8'h81, 8'h55, 8'hAA, 8'h00};
        aresetn           = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        cfg_valid         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        src_idling        = 1'b1;
        sink_idling       = 1'b1;
        sink_hold_request = 1'b0;
        stall_cycles      = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset weights: lost line with zero saved error, then a single sensor
        send_snapshot(sensor_pins(8'h00));
        send_snapshot(sensor_pins(8'h01));

        // Spread weights, extremes at the ends; some means do not divide evenly
        wait_all_results();
        weight_plan = '{16'h8000, 16'(-20000), 16'(-7000), 16'(-1000),
                        16'd1000, 16'd7000, 16'd20000, 16'h7FFF};
        write_cfg(4'd15, 16'hFFFF);
        load_weights(2);
        foreach (ramp_masks[i]) send_snapshot(sensor_pins(ramp_masks[i]));

        // All weights at the positive extreme
        wait_all_results();
        foreach (weight_plan[k]) weight_plan[k] = 16'h7FFF;
        load_weights(0);
        send_snapshot(sensor_pins(8'hFF));
        send_snapshot(sensor_pins(8'h01));
        send_snapshot(sensor_pins(8'h07));

        // All weights at the negative extreme: largest negative sum
        wait_all_results();
        foreach (weight_plan[k]) weight_plan[k] = 16'h8000;
        load_weights(1);
        send_snapshot(sensor_pins(8'hFF));
        send_snapshot(sensor_pins(8'h07));
        send_snapshot(sensor_pins(8'h00));

        // Random phases, each with fresh weights; the last one runs without idling
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_all_results();
            foreach (weight_plan[k]) weight_plan[k] = pick_weight();
            load_weights($urandom_range(0, 3));
            last_phase  = (phase == RANDOM_PHASES - 1);
            src_idling  = !last_phase;
            sink_idling = !last_phase;
            if (phase == 1) begin
                // receiver holds off while snapshots keep coming, so the input stalls
                sink_hold_request = 1'b1;
                src_idling = 1'b0;
                for (n = 0; n < 12; n++) send_snapshot(pick_levels());
                src_idling = 1'b1;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_snapshot(pick_levels());
                if (!last_phase && $urandom_range(0, 49) == 0) wait_all_results();
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.outstanding() != 0)
            $display("%0t: %0d expected results never arrived",
                     $time, tracker.outstanding());
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
